FILE: rtl/cbd_pkg.sv
// Package with the request types, phase codes and byte constants of the chunked body decoder.
package cbd_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       stream_end;
    } t_in_req;

    typedef struct packed {
        logic [7:0] body_byte;
        logic [1:0] kind;
    } t_out_req;

    typedef struct packed {
        logic    valid;
        t_in_req req;
    } t_in_slot;

    typedef struct packed {
        logic     valid;
        t_out_req req;
    } t_result;

    typedef enum logic [3:0] {
        PH_SIZE    = 4'd0,
        PH_SIZE_LF = 4'd1,
        PH_EXT     = 4'd2,
        PH_EXT_LF  = 4'd3,
        PH_DATA    = 4'd4,
        PH_DATA_CR = 4'd5,
        PH_DATA_LF = 4'd6,
        PH_DONE    = 4'd7,
        PH_FAILED  = 4'd8
    } t_phase;

    localparam logic [1:0] KIND_BYTE  = 2'd0;
    localparam logic [1:0] KIND_DONE  = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_LOW_A = 8'h61;
    localparam logic [7:0] CH_LOW_F = 8'h66;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_F  = 8'h46;
    localparam logic [7:0] HEX_TEN  = 8'd10;

    // Returns a valid flag in the top bit and the digit value below it.
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [7:0] v;
        v = 8'd0;
        if (c >= CH_ZERO && c <= CH_NINE) begin
            v = c - CH_ZERO;
            return {1'b1, v[3:0]};
        end else if (c >= CH_LOW_A && c <= CH_LOW_F) begin
            v = c - CH_LOW_A + HEX_TEN;
            return {1'b1, v[3:0]};
        end else if (c >= CH_UP_A && c <= CH_UP_F) begin
            v = c - CH_UP_A + HEX_TEN;
            return {1'b1, v[3:0]};
        end
        return 5'd0;
    endfunction

endpackage

FILE: rtl/cbd_in_stage.sv
// Input register that holds one request until the parser can take it.
module cbd_in_stage (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  cbd_pkg::t_in_req i_in_req,
    input  logic             i_advance,
    output cbd_pkg::t_in_slot o_slot
);
    import cbd_pkg::*;

    logic    r_valid;
    t_in_req r_req;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_advance) begin
            r_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_advance && i_in_valid) begin
            r_req <= i_in_req;
        end
    end

    assign o_slot = '{valid: r_valid, req: r_req};

endmodule

FILE: rtl/cbd_parser.sv
// Framing state machine and size counter that decode one request per enabled cycle.
module cbd_parser #(
    parameter int SIZE_BITS = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  cbd_pkg::t_in_req i_req,
    output cbd_pkg::t_result o_res
);
    import cbd_pkg::*;

    t_phase                r_phase, n_phase;
    logic                  r_seen, n_seen;
    logic [SIZE_BITS-1:0]  r_left, n_left;
    logic [SIZE_BITS-1:0]  left_dec;
    logic [4:0]            hex;
    logic                  res_valid;
    logic [1:0]            res_kind;
    logic [7:0]            res_byte;
    logic [7:0]            c;

    assign c        = i_req.data_byte;
    assign hex      = hex_value(c);
    assign left_dec = r_left - {{(SIZE_BITS-1){1'b0}}, 1'b1};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_SIZE;
            r_seen  <= 1'b0;
            r_left  <= '0;
        end else if (i_en) begin
            r_phase <= n_phase;
            r_seen  <= n_seen;
            r_left  <= n_left;
        end
    end

    always_comb begin
        n_phase   = r_phase;
        n_seen    = r_seen;
        n_left    = r_left;
        res_valid = 1'b0;
        res_kind  = KIND_BYTE;
        res_byte  = 8'd0;
        if (i_req.stream_end) begin
            n_phase   = PH_SIZE;
            n_seen    = 1'b0;
            n_left    = '0;
            res_valid = !(r_phase == PH_DONE || r_phase == PH_FAILED);
            res_kind  = KIND_ERROR;
        end else begin
            case (r_phase)
                PH_SIZE: begin
                    if (c == CH_SEMI || c == CH_CR) begin
                        if (!r_seen) begin
                            n_phase   = PH_FAILED;
                            res_valid = 1'b1;
                            res_kind  = KIND_ERROR;
                        end else begin
                            n_phase = (c == CH_SEMI) ? PH_EXT : PH_SIZE_LF;
                        end
                    end else if (!hex[4] || r_left[SIZE_BITS-1 -: 4] != 4'd0) begin
                        n_phase   = PH_FAILED;
                        res_valid = 1'b1;
                        res_kind  = KIND_ERROR;
                    end else begin
                        n_left = {r_left[SIZE_BITS-5:0], hex[3:0]};
                        n_seen = 1'b1;
                    end
                end
                PH_SIZE_LF, PH_EXT_LF: begin
                    if (c == CH_LF) begin
                        if (!r_seen) begin
                            n_phase   = PH_FAILED;
                            res_valid = 1'b1;
                            res_kind  = KIND_ERROR;
                        end else if (r_left == '0) begin
                            n_phase   = PH_DONE;
                            res_valid = 1'b1;
                            res_kind  = KIND_DONE;
                        end else begin
                            n_phase = PH_DATA;
                        end
                    end else if (r_phase == PH_SIZE_LF) begin
                        n_phase   = PH_FAILED;
                        res_valid = 1'b1;
                        res_kind  = KIND_ERROR;
                    end else if (c != CH_CR) begin
                        n_phase = PH_EXT;
                    end
                end
                PH_EXT: begin
                    if (c == CH_CR) begin
                        n_phase = PH_EXT_LF;
                    end
                end
                PH_DATA: begin
                    n_left    = left_dec;
                    res_valid = 1'b1;
                    res_kind  = KIND_BYTE;
                    res_byte  = c;
                    if (left_dec == '0) begin
                        n_phase = PH_DATA_CR;
                    end
                end
                PH_DATA_CR: begin
                    if (c != CH_CR) begin
                        n_phase   = PH_FAILED;
                        res_valid = 1'b1;
                        res_kind  = KIND_ERROR;
                    end else begin
                        n_phase = PH_DATA_LF;
                    end
                end
                PH_DATA_LF: begin
                    if (c != CH_LF) begin
                        n_phase   = PH_FAILED;
                        res_valid = 1'b1;
                        res_kind  = KIND_ERROR;
                    end else begin
                        n_phase = PH_SIZE;
                        n_seen  = 1'b0;
                        n_left  = '0;
                    end
                end
                PH_DONE: begin
                    n_phase = PH_DONE;
                end
                default: begin
                    n_phase = PH_FAILED;
                end
            endcase
        end
    end

    assign o_res = '{valid: res_valid, req: '{body_byte: res_byte, kind: res_kind}};

endmodule

FILE: rtl/chunked_body_decoder.sv
// Top level of the chunked body decoder with its result register and assertions.
//
// The input channel carries one received body byte or an end-of-stream mark
// per request; the output channel carries decoded payload bytes, a body
// complete mark or a framing error. A request that gives a result passes
// the input register and the parser and is then loaded into the result
// register, from which the receiver takes it. Requests that give no result
// leave nothing on the output. One request is taken in every cycle in which
// the input stall is low: each one passes the input register and the parser
// once, and the parser updates its size counter and phase register as it
// processes the request. A result waiting in the result register does not
// block the next request unless the receiver stalls; while the receiver
// stalls and the result register is full, a request in the input register
// is held there and the input stall rises in the same cycle. Reset clears
// both registers and puts the parser at the start of a size line with a zero
// counter. An end-of-stream request resets the parser the same way, giving an
// error result first if the body was not yet complete and no error was reported.
module chunked_body_decoder #(
    parameter int SIZE_BITS = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  cbd_pkg::t_in_req  i_in_req,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output cbd_pkg::t_out_req o_out_req
);
    import cbd_pkg::*;

    t_in_slot slot;
    t_result  res;
    logic     out_free;
    logic     proc;
    logic     advance;
    logic     r_out_valid;
    t_out_req r_out_req;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign proc       = slot.valid && out_free;
    assign advance    = !slot.valid || proc;
    assign o_in_stall = !advance;

    cbd_in_stage u_in_stage (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_req   (i_in_req),
        .i_advance  (advance),
        .o_slot     (slot)
    );

    cbd_parser #(
        .SIZE_BITS (SIZE_BITS)
    ) u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (proc),
        .i_req   (slot.req),
        .o_res   (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= proc && res.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (proc && res.valid) begin
            r_out_req <= res.req;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_req   = r_out_req;

`ifndef NO_ASSERTIONS
    a_kind_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_req.kind == KIND_BYTE || o_out_req.kind == KIND_DONE
                         || o_out_req.kind == KIND_ERROR))
        else $error("Result kind out of range.");

    a_mark_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_req.kind != KIND_BYTE) |-> o_out_req.body_byte == 8'd0)
        else $error("Completion or error result carries a nonzero byte.");

    a_in_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> slot.valid)
        else $error("Accepted request did not reach the input register.");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_out_valid && i_out_stall))
        else $error("Input stalled while the result register could drain.");
`endif

endmodule
